// File: rtl/core/atlp_pkg.sv
package atlp_pkg;

  // Line length handling: bytes at position LineLimit-1 and beyond are dropped
  localparam int unsigned LineLimit = 256;
  localparam int unsigned PosW      = $clog2(LineLimit);
  localparam logic [PosW-1:0] PosMax = PosW'(LineLimit - 1);

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned FieldW = 4;

  localparam logic [FieldW-1:0] FieldMax = '1;
  localparam logic [ValueW-1:0] MagMax   = 32'h7FFF_FFFF;

  // ASCII codes
  localparam logic [ByteW-1:0] CharM     = 8'h6D;
  localparam logic [ByteW-1:0] CharT     = 8'h74;
  localparam logic [ByteW-1:0] CharL     = 8'h6C;
  localparam logic [ByteW-1:0] CharR     = 8'h72;
  localparam logic [ByteW-1:0] CharS     = 8'h73;
  localparam logic [ByteW-1:0] CharA     = 8'h61;
  localparam logic [ByteW-1:0] CharY     = 8'h79;
  localparam logic [ByteW-1:0] CharComma = 8'h2C;
  localparam logic [ByteW-1:0] CharMinus = 8'h2D;
  localparam logic [ByteW-1:0] CharNl    = 8'h0A;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;

  typedef enum logic [2:0] {
    TypeNone  = 3'd0,
    TypeLeft  = 3'd1,
    TypeRight = 3'd2,
    TypeAccel = 3'd3,
    TypeGyro  = 3'd4
  } line_type_e;

  // Result kind codes
  localparam logic [KindW-1:0] KindLeft  = 2'd0;
  localparam logic [KindW-1:0] KindRight = 2'd1;
  localparam logic [KindW-1:0] KindAccel = 2'd2;
  localparam logic [KindW-1:0] KindGyro  = 2'd3;

endpackage

// File: rtl/core/atlp_rx_if.sv
interface atlp_rx_if;
  import atlp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/atlp_res_if.sv
interface atlp_res_if;
  import atlp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [KindW-1:0]  line_kind;
  logic signed [ValueW-1:0] value_a;
  logic signed [ValueW-1:0] value_b;
  logic signed [ValueW-1:0] value_c;

  modport source (output valid, output line_kind, output value_a, output value_b,
                  output value_c, input ready);
  modport sink   (input valid, input line_kind, input value_a, input value_b,
                  input value_c, output ready);
endinterface

// File: rtl/core/ascii_telemetry_line_parser.sv
// Timing: a byte is registered in the input register on accept and parsed from there; the result of a
//   newline is loaded into the result register, which drives res_o.
// Throughput: one byte per cycle while no result waits on res_o with the input register full.
//   rx_i stalls only while a result waits on res_o and the input register is full.
// Reset (rst_ni low, asynchronous): parser state cleared to the start of an empty line,
//   both the input register and the result register empty.
module ascii_telemetry_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  atlp_rx_if.sink     rx_i,
  atlp_res_if.source  res_o
);
  import atlp_pkg::*;

  // Input register
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             advance;

  // Parser state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ByteW-1:0]  prefix0_q, prefix0_d;
  logic [ByteW-1:0]  prefix1_q, prefix1_d;
  line_type_e        type_q, type_d, type_n;
  logic [FieldW-1:0] field_q, field_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic              minus_q, minus_d;
  logic [ValueW-1:0] cap_q [3];
  logic [ValueW-1:0] cap_d [3];

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [KindW-1:0]  out_kind_q, out_kind_d;
  logic [ValueW-1:0] out_val_q [3];
  logic [ValueW-1:0] out_val_d [3];

  // Scratch
  logic              emit;
  logic [2:0]        slot_nl, slot_pb;
  logic [ValueW-1:0] commit_val;
  logic [PosW-1:0]   start_pos;
  logic [ValueW+3:0] acc_x10;
  logic [3:0]        digit;

  // Captured-value slot (one-hot) for the current field of a line type
  function automatic logic [2:0] slot_of(line_type_e t, logic [FieldW-1:0] f);
    logic [2:0] s;
    s = 3'b000;
    case (t)
      TypeLeft, TypeRight: if (f == FieldW'(0)) s = 3'b001;
      TypeAccel: begin
        if (f == FieldW'(2)) s = 3'b001;
        else if (f == FieldW'(5)) s = 3'b010;
        else if (f == FieldW'(7)) s = 3'b100;
      end
      TypeGyro: begin
        if (f == FieldW'(0)) s = 3'b001;
        else if (f == FieldW'(1)) s = 3'b010;
        else if (f == FieldW'(2)) s = 3'b100;
      end
      default: s = 3'b000;
    endcase
    return s;
  endfunction

  function automatic logic [KindW-1:0] kind_of(line_type_e t);
    logic [KindW-1:0] k;
    case (t)
      TypeLeft:  k = KindLeft;
      TypeRight: k = KindRight;
      TypeAccel: k = KindAccel;
      TypeGyro:  k = KindGyro;
      default:   k = KindLeft;
    endcase
    return k;
  endfunction

  // Handshake: parse when the result slot is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;
  assign in_valid_d = (in_valid_q && !advance) || (rx_i.valid && rx_i.ready);

  // Signed field value from magnitude and sign parity
  assign commit_val = minus_q ? (ValueW'(0) - acc_q) : acc_q;

  // Decimal accumulate, saturating at MagMax
  assign digit   = in_byte_q[3:0] - CharZero[3:0];
  assign acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (ValueW + 4)'(digit);

  // Parser next state and result load
  always_comb begin
    pos_d     = pos_q;
    prefix0_d = prefix0_q;
    prefix1_d = prefix1_q;
    type_d    = type_q;
    type_n    = type_q;
    field_d   = field_q;
    acc_d     = acc_q;
    minus_d   = minus_q;
    cap_d     = cap_q;
    emit      = 1'b0;
    slot_nl   = slot_of(type_q, field_q);
    slot_pb   = 3'b000;
    start_pos = PosW'(3);
    out_kind_d = out_kind_q;
    out_val_d  = out_val_q;

    if (advance) begin
      if (in_byte_q == CharNl) begin
        // End of line: commit open field, report if the line type is known, start fresh
        if (type_q != TypeNone) begin
          emit       = 1'b1;
          out_kind_d = kind_of(type_q);
          for (int i = 0; i < 3; i++) begin
            out_val_d[i] = slot_nl[i] ? commit_val : cap_q[i];
          end
        end
        pos_d     = '0;
        prefix0_d = '0;
        prefix1_d = '0;
        type_d    = TypeNone;
        field_d   = '0;
        acc_d     = '0;
        minus_d   = 1'b0;
        for (int i = 0; i < 3; i++) cap_d[i] = '0;
      end else if (pos_q < PosMax) begin
        // Prefix recognition
        if (pos_q == PosW'(0)) begin
          prefix0_d = in_byte_q;
        end else if (pos_q == PosW'(1)) begin
          prefix1_d = in_byte_q;
          if (prefix0_q == CharS && in_byte_q == CharA) type_n = TypeAccel;
          else if (prefix0_q == CharS && in_byte_q == CharY) type_n = TypeGyro;
        end else if (pos_q == PosW'(2) && type_q == TypeNone) begin
          if (prefix0_q == CharM && prefix1_q == CharT) begin
            if (in_byte_q == CharL) type_n = TypeLeft;
            else if (in_byte_q == CharR) type_n = TypeRight;
          end
        end
        type_d = type_n;

        // Field parsing
        start_pos = (type_n == TypeAccel || type_n == TypeGyro) ? PosW'(2) : PosW'(3);
        slot_pb   = slot_of(type_n, field_q);
        if (type_n != TypeNone && pos_q >= start_pos) begin
          if (in_byte_q == CharComma) begin
            if (pos_q != start_pos) begin
              for (int i = 0; i < 3; i++) begin
                if (slot_pb[i]) cap_d[i] = commit_val;
              end
              if (field_q < FieldMax) field_d = field_q + FieldW'(1);
              acc_d   = '0;
              minus_d = 1'b0;
            end
          end else if (in_byte_q == CharMinus) begin
            minus_d = !minus_q;
          end else if (in_byte_q >= CharZero && in_byte_q <= CharNine) begin
            acc_d = (acc_x10 > {4'b0, MagMax}) ? MagMax : acc_x10[ValueW-1:0];
          end
        end
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  assign out_valid_d = (out_valid_q && !res_o.ready) || emit;

  // Control and parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      prefix0_q   <= '0;
      prefix1_q   <= '0;
      type_q      <= TypeNone;
      field_q     <= '0;
      acc_q       <= '0;
      minus_q     <= 1'b0;
      for (int i = 0; i < 3; i++) cap_q[i] <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      prefix0_q   <= prefix0_d;
      prefix1_q   <= prefix1_d;
      type_q      <= type_d;
      field_q     <= field_d;
      acc_q       <= acc_d;
      minus_q     <= minus_d;
      cap_q       <= cap_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) in_byte_q <= rx_i.rx_byte;
    out_kind_q <= out_kind_d;
    out_val_q  <= out_val_d;
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.line_kind = out_kind_q;
  assign res_o.value_a   = out_val_q[0];
  assign res_o.value_b   = out_val_q[1];
  assign res_o.value_c   = out_val_q[2];

`ifndef SYNTH
  // A new result only follows a parsed newline
  a_result_from_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && in_byte_q == CharNl))
    else $error("result raised without a newline");

  // Line position never passes the saturation point
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("line position out of range");

  // A newline leaves the parser at the start of an empty line
  a_newline_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_byte_q == CharNl) |=>
      (pos_q == '0 && type_q == TypeNone && field_q == '0 && acc_q == '0 && !minus_q))
    else $error("line state not cleared after newline");

  // Input stalls only with a byte held that cannot be parsed
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (in_valid_q && out_valid_q && !res_o.ready))
    else $error("input stalled without cause");
`endif

endmodule

// File: verif/ascii_telemetry_line_parser_tb.sv
`timescale 1ns / 100ps

module ascii_telemetry_line_parser_tb;
  import atlp_pkg::*;

  localparam int unsigned TotalBytes    = 1600;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned MaxReports    = 10;

  typedef struct packed {
    logic        [KindW-1:0]  kind;
    logic signed [ValueW-1:0] a;
    logic signed [ValueW-1:0] b;
    logic signed [ValueW-1:0] c;
  } telemetry_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  atlp_rx_if  rx_if ();
  atlp_res_if res_if ();

  ascii_telemetry_line_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // stimulus and expectations
  logic [ByteW-1:0] rx_bytes[$];
  telemetry_t       expected_lines[$];
  int unsigned      bytes_total;
  int unsigned      bytes_accepted;
  int unsigned      mismatches;
  int unsigned      idle_cycles;
  bit               byte_taken;
  bit               hold_results;
  int unsigned      send_gap;
  int unsigned      send_quiet;
  int unsigned      take_gap;
  int unsigned      take_quiet;

  // line parser state, mirrored
  int unsigned      line_pos;
  logic [ByteW-1:0] first_char;
  logic [ByteW-1:0] second_char;
  line_type_e       cur_type;
  logic [FieldW-1:0] field_no;
  logic [ValueW-1:0] magnitude;
  logic             negate;
  logic [ValueW-1:0] captured[3];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // gap lengths: mostly none or short, a few long, and now and then a quiet run
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned roll;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    roll = $urandom_range(0, 999);
    if (roll < 4) begin
      quiet = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 600) return 0;
    if (roll < 900) return $urandom_range(1, 3);
    if (roll < 985) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_line_state();
    line_pos    = 0;
    first_char  = '0;
    second_char = '0;
    cur_type    = TypeNone;
    field_no    = '0;
    magnitude   = '0;
    negate      = 1'b0;
    foreach (captured[i]) captured[i] = '0;
  endfunction

  // which captured slot the current field lands in, -1 if not reported
  function automatic int field_slot();
    case (cur_type)
      TypeLeft, TypeRight: return (field_no == 0) ? 0 : -1;
      TypeAccel: begin
        if (field_no == 2) return 0;
        if (field_no == 5) return 1;
        if (field_no == 7) return 2;
        return -1;
      end
      TypeGyro: return (field_no <= 2) ? int'(field_no) : -1;
      default: return -1;
    endcase
  endfunction

  function automatic void store_field();
    int slot;
    slot = field_slot();
    if (slot >= 0) captured[slot] = negate ? -magnitude : magnitude;
  endfunction

  // advance the line state by one accepted byte, queue a result on newline
  function automatic void parse_telemetry_byte(input logic [ByteW-1:0] b);
    int unsigned start;
    logic [63:0] grown;
    telemetry_t  line_out;
    if (b == CharNl) begin
      if (cur_type != TypeNone) begin
        store_field();
        case (cur_type)
          TypeLeft:  line_out.kind = KindLeft;
          TypeRight: line_out.kind = KindRight;
          TypeAccel: line_out.kind = KindAccel;
          default:   line_out.kind = KindGyro;
        endcase
        line_out.a = captured[0];
        line_out.b = captured[1];
        line_out.c = captured[2];
        expected_lines.push_back(line_out);
      end
      clear_line_state();
      return;
    end
    // overlong line: drop until newline
    if (line_pos >= PosMax) return;

    // prefix decode
    if (line_pos == 0) begin
      first_char = b;
    end else if (line_pos == 1) begin
      second_char = b;
      if (first_char == CharS && b == CharA) cur_type = TypeAccel;
      else if (first_char == CharS && b == CharY) cur_type = TypeGyro;
    end else if (line_pos == 2 && cur_type == TypeNone && first_char == CharM &&
                 second_char == CharT) begin
      if (b == CharL) cur_type = TypeLeft;
      else if (b == CharR) cur_type = TypeRight;
    end

    // field parse
    if (cur_type != TypeNone) begin
      start = (cur_type == TypeAccel || cur_type == TypeGyro) ? 2 : 3;
      if (line_pos >= start) begin
        if (b == CharComma) begin
          // comma right at the start position is skipped
          if (line_pos != start) begin
            store_field();
            if (field_no != FieldMax) field_no++;
            magnitude = '0;
            negate    = 1'b0;
          end
        end else if (b == CharMinus) begin
          negate = ~negate;
        end else if (b >= CharZero && b <= CharNine) begin
          grown     = {32'd0, magnitude} * 64'd10 + 64'(b - CharZero);
          magnitude = (grown > 64'(MagMax)) ? MagMax : grown[31:0];
        end
      end
    end
    line_pos++;
  endfunction

  // stimulus builders
  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) rx_bytes.push_back(s[i]);
  endfunction

  function automatic void push_number();
    int unsigned minus_cnt;
    int unsigned shape;
    logic [ByteW-1:0] junk;
    minus_cnt = ($urandom_range(0, 2) == 0) ? 1 : 0;
    if ($urandom_range(0, 19) == 0) minus_cnt = $urandom_range(2, 3);
    repeat (minus_cnt) rx_bytes.push_back(CharMinus);
    shape = $urandom_range(0, 9);
    if (shape < 4) begin
      push_str($sformatf("%0d", $urandom_range(0, 999)));
    end else if (shape < 7) begin
      push_str($sformatf("%0d", $urandom()));
    end else if (shape < 8) begin
      // runs past the saturation point
      repeat ($urandom_range(10, 14))
        rx_bytes.push_back(CharZero + ByteW'($urandom_range(0, 9)));
    end else if (shape < 9) begin
      push_str($sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 999)));
    end
    if ($urandom_range(0, 9) == 0) begin
      junk = ByteW'($urandom_range(0, 255));
      rx_bytes.push_back((junk == CharNl) ? 8'h20 : junk);
    end
  endfunction

  function automatic void push_random_line();
    string broken[11] = '{"mt", "m", "s", "sx", "mtq", "tml", "ms", "ys", "mtL", "SA", ""};
    int unsigned style;
    int unsigned nfields;
    style = $urandom_range(0, 99);
    if (style < 75) begin
      // well-formed line with random content
      case ($urandom_range(0, 3))
        0:       push_str("mtl");
        1:       push_str("mtr");
        2:       push_str("sa");
        default: push_str("sy");
      endcase
      if ($urandom_range(0, 5) == 0) rx_bytes.push_back(CharComma);
      nfields = $urandom_range(0, 9);
      for (int k = 0; k < nfields; k++) begin
        if (k > 0) rx_bytes.push_back(CharComma);
        push_number();
      end
    end else if (style < 88) begin
      push_str(broken[$urandom_range(0, 10)]);
      push_number();
    end else if (style < 99) begin
      repeat ($urandom_range(1, 20)) rx_bytes.push_back(ByteW'($urandom_range(0, 255)));
    end else begin
      // overlong line
      push_str(($urandom_range(0, 1) == 0) ? "mtr" : "sa");
      repeat ($urandom_range(250, 300)) begin
        case ($urandom_range(0, 11))
          0:       rx_bytes.push_back(CharComma);
          1:       rx_bytes.push_back(CharMinus);
          default: rx_bytes.push_back(CharZero + ByteW'($urandom_range(0, 9)));
        endcase
      end
    end
    rx_bytes.push_back(CharNl);
  endfunction

  // byte sender
  always @(negedge clk_i) begin
    if (rst_ni && !(rx_if.valid && !byte_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        rx_if.valid <= 1'b0;
      end else if (rx_bytes.size() > 0) begin
        rx_if.rx_byte <= rx_bytes.pop_front();
        rx_if.valid   <= 1'b1;
        send_gap = pick_gap(send_quiet);
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (!rst_ni || hold_results) begin
      res_if.ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      take_gap = pick_gap(take_quiet);
    end
  end

  // long receiver stall once the stream is well underway
  initial begin
    hold_results = 1'b0;
    while (bytes_accepted < 500) @(posedge clk_i);
    hold_results = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_results = 1'b0;
  end

  // monitor: predict on byte accept, check on result accept
  always @(posedge clk_i) begin
    telemetry_t got;
    telemetry_t want;
    bit         result_taken;
    if (rst_ni) begin
      byte_taken   = rx_if.valid && rx_if.ready;
      result_taken = res_if.valid && res_if.ready;
      if (byte_taken) begin
        parse_telemetry_byte(rx_if.rx_byte);
        bytes_accepted++;
      end
      if (result_taken) begin
        got = '{kind: res_if.line_kind, a: res_if.value_a, b: res_if.value_b,
                c: res_if.value_c};
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result: kind %0d a %0d b %0d c %0d",
                     got.kind, got.a, got.b, got.c);
        end else begin
          want = expected_lines.pop_front();
          if (got.kind !== want.kind || got.a !== want.a || got.b !== want.b ||
              got.c !== want.c) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display({"result mismatch: expected kind %0d a %0d b %0d c %0d, ",
                        "got kind %0d a %0d b %0d c %0d"},
                       want.kind, want.a, want.b, want.c, got.kind, got.a, got.b, got.c);
          end
        end
      end
      idle_cycles = (byte_taken || result_taken) ? 0 : idle_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (idle_cycles < WatchdogLimit) @(negedge clk_i);
    $display("ascii_telemetry_line_parser verification failed");
    $finish;
  end

  initial begin
    string long_line;
    rst_ni         = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    bytes_accepted = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    byte_taken     = 1'b0;
    send_gap       = 0;
    send_quiet     = 0;
    take_gap       = 0;
    take_quiet     = 0;
    clear_line_state();

    // directed lines: each kind, signs, saturation, skipped comma, missing fields
    push_str("mtl123");                 rx_bytes.push_back(CharNl);
    push_str("mtr-45");                 rx_bytes.push_back(CharNl);
    push_str("mtl--7");                 rx_bytes.push_back(CharNl);
    push_str("sa0,1,2,3,4,5,6,7");      rx_bytes.push_back(CharNl);
    push_str("sy-1,2,-3");              rx_bytes.push_back(CharNl);
    push_str("sa,1,2");                 rx_bytes.push_back(CharNl);
    push_str("mtl,5");                  rx_bytes.push_back(CharNl);
    push_str("sy");                     rx_bytes.push_back(CharNl);
    push_str("mtr");                    rx_bytes.push_back(CharNl);
    push_str("mtl2147483647");          rx_bytes.push_back(CharNl);
    push_str("mtr2147483648");          rx_bytes.push_back(CharNl);
    push_str("mtl-99999999999");        rx_bytes.push_back(CharNl);
    push_str("sy4294967295,-4294967296,9");  rx_bytes.push_back(CharNl);
    push_str("sa,,1,,,-2,,3,,,,,,,,,,,,,4"); rx_bytes.push_back(CharNl);
    push_str("mtl1");
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    push_str("2");                      rx_bytes.push_back(CharNl);
    push_str("s");                      rx_bytes.push_back(CharNl);
    rx_bytes.push_back(CharNl);
    push_str("mt");                     rx_bytes.push_back(CharNl);
    push_str("mtx5");                   rx_bytes.push_back(CharNl);
    push_str("smtl5");                  rx_bytes.push_back(CharNl);
    // line limit: digits at positions 253 and 254 count, later ones are dropped
    long_line = "mtl";
    repeat (250) long_line = {long_line, "0"};
    long_line = {long_line, "78955,-"};
    push_str(long_line);                rx_bytes.push_back(CharNl);

    // random lines fill the stream up to the total
    bytes_total = TotalBytes;
    while (rx_bytes.size() < bytes_total) push_random_line();
    bytes_total = rx_bytes.size();

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_accepted < bytes_total) @(negedge clk_i);
    while (expected_lines.size() > 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("ascii_telemetry_line_parser verification clean");
    end else begin
      $display("ascii_telemetry_line_parser verification failed");
    end
    $finish;
  end

endmodule
